[hdl/two_level_sparse_array_top_defines.svh]
// ============================================================================
// Two-level sparse array assertion macros
// Shared assertion forms for the port checker, clocked on clk, off in reset.
// ============================================================================
`ifndef TWO_LEVEL_SPARSE_ARRAY_TOP_DEFINES_SVH
`define TWO_LEVEL_SPARSE_ARRAY_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TLSA_CHK_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlsa port check failed");

// Consequent must hold in the cycle after the antecedent.
`define TLSA_CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlsa port check failed");

`endif

[hdl/tlsa_pkg.sv]
// ============================================================================
// Two-level sparse array package
// Sizes, derived widths, request codes and controller states.
// ============================================================================
package tlsa_pkg;

    localparam int SLOTS        = 256;
    localparam int PAGE_ENTRIES = 256;   // power of two
    localparam int POOL_PAGES   = 64;
    localparam int VALUE_BITS   = 32;

    localparam int IDX_W  = 16;
    localparam int OUT_W  = 32;
    localparam int ENT_W  = $clog2(PAGE_ENTRIES);
    localparam int SLOT_W = IDX_W - ENT_W;
    localparam int DIR_AW = $clog2(SLOTS);
    localparam int PG_W   = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
    localparam int CNT_W  = $clog2(POOL_PAGES + 1);
    localparam int VAL_W  = (VALUE_BITS < OUT_W) ? VALUE_BITS : OUT_W;
    localparam int WORD_AW = PG_W + ENT_W;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIR   = 4'b0010,
        S_PAGE  = 4'b0100,
        S_SWEEP = 4'b1000
    } state_t;

endpackage

[hdl/two_level_sparse_array_top.sv]
// ============================================================================
// Two-level sparse array
// Directory of page numbers plus a pool of pages, one request at a time.
// ============================================================================
// A request beat is taken when start is high and busy is low; its single
// result shows for one cycle with done high and must be captured then. The
// result of a read that finds a page comes after the directory read and the
// page read; every other request answers after the directory read, except a
// write that takes a fresh page from the pool, which answers after a sweep of
// all PAGE_ENTRIES words of the new page, zeroed one word per cycle through the
// single write port of the page memory, with the written value merged in on
// the way. busy drops in the cycle done is shown, so the next request beat can
// be taken there. Clear takes effect at once on the directory valid bits.
// ============================================================================
module two_level_sparse_array_top
    import tlsa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       req_type,
    input  logic [IDX_W-1:0] entry_index,
    input  logic [31:0]      write_value,
    output logic             done,
    output logic [OUT_W-1:0] read_value,
    output logic             page_found,
    output logic             pool_full
);

    state_t              state_reg, state_next;
    logic [SLOTS-1:0]    valid_reg, valid_next;
    logic [CNT_W-1:0]    used_reg, used_next;
    logic [PG_W-1:0]     page_reg, page_next;
    logic [ENT_W-1:0]    sweep_reg, sweep_next;
    logic                done_reg, done_next;

    req_t                req_reg, req_next;
    logic [DIR_AW-1:0]   slot_reg, slot_next;
    logic                slot_ok_reg, slot_ok_next;
    logic [ENT_W-1:0]    ent_reg, ent_next;
    logic [VAL_W-1:0]    val_reg, val_next;
    logic [OUT_W-1:0]    rv_reg, rv_next;
    logic                found_reg, found_next;
    logic                full_reg, full_next;

    logic [SLOT_W-1:0]   slot_in;
    logic                hit;

    logic                dir_we;
    logic [DIR_AW-1:0]   dir_raddr;
    logic [PG_W-1:0]     dir_wdata;
    logic [PG_W-1:0]     dir_rdata;

    logic                pg_we;
    logic [WORD_AW-1:0]  pg_waddr;
    logic [WORD_AW-1:0]  pg_raddr;
    logic [VAL_W-1:0]    pg_wdata;
    logic [VAL_W-1:0]    pg_rdata;

    assign slot_in   = entry_index[IDX_W-1:ENT_W];
    assign dir_raddr = DIR_AW'(slot_in);
    assign hit       = slot_ok_reg && valid_reg[slot_reg];
    assign dir_wdata = used_reg[PG_W-1:0];

    tlsa_ram #(
        .WIDTH (PG_W),
        .DEPTH (2 ** DIR_AW)
    ) u_dir_ram (
        .clk   (clk),
        .we    (dir_we),
        .waddr (slot_reg),
        .wdata (dir_wdata),
        .raddr (dir_raddr),
        .rdata (dir_rdata)
    );

    tlsa_ram #(
        .WIDTH (VAL_W),
        .DEPTH (2 ** WORD_AW)
    ) u_page_ram (
        .clk   (clk),
        .we    (pg_we),
        .waddr (pg_waddr),
        .wdata (pg_wdata),
        .raddr (pg_raddr),
        .rdata (pg_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        valid_next   = valid_reg;
        used_next    = used_reg;
        page_next    = page_reg;
        sweep_next   = sweep_reg;
        done_next    = 1'b0;
        req_next     = req_reg;
        slot_next    = slot_reg;
        slot_ok_next = slot_ok_reg;
        ent_next     = ent_reg;
        val_next     = val_reg;
        rv_next      = rv_reg;
        found_next   = found_reg;
        full_next    = full_reg;
        dir_we       = 1'b0;
        pg_we        = 1'b0;
        pg_waddr     = {dir_rdata, ent_reg};
        pg_raddr     = {dir_rdata, ent_reg};
        pg_wdata     = val_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next     = req_t'(req_type);
                    slot_next    = DIR_AW'(slot_in);
                    slot_ok_next = {1'b0, slot_in} < (SLOT_W + 1)'(SLOTS);
                    ent_next     = entry_index[ENT_W-1:0];
                    val_next     = write_value[VAL_W-1:0];
                    state_next   = S_DIR;
                end
            end

            S_DIR:
            begin
                // Directory entry is on the RAM output now.
                state_next = S_IDLE;
                done_next  = 1'b1;
                rv_next    = '0;
                found_next = 1'b0;
                full_next  = 1'b0;
                unique case (req_reg)
                    REQ_READ:
                    begin
                        if (hit)
                        begin
                            state_next = S_PAGE;
                            done_next  = 1'b0;
                        end
                    end
                    REQ_WRITE:
                    begin
                        if (slot_ok_reg)
                        begin
                            if (hit)
                            begin
                                pg_we      = 1'b1;
                                found_next = 1'b1;
                            end
                            else if (used_reg < CNT_W'(POOL_PAGES))
                            begin
                                dir_we               = 1'b1;
                                valid_next[slot_reg] = 1'b1;
                                used_next            = used_reg + CNT_W'(1);
                                page_next            = used_reg[PG_W-1:0];
                                sweep_next           = '0;
                                state_next           = S_SWEEP;
                                done_next            = 1'b0;
                            end
                            else
                            begin
                                full_next = 1'b1;
                            end
                        end
                    end
                    REQ_CLEAR:
                    begin
                        valid_next = '0;
                        used_next  = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_PAGE:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                rv_next    = OUT_W'(pg_rdata);
                found_next = 1'b1;
                full_next  = 1'b0;
            end

            S_SWEEP:
            begin
                // Zero the fresh page, storing the write value at its entry.
                pg_we      = 1'b1;
                pg_waddr   = {page_reg, sweep_reg};
                pg_wdata   = (sweep_reg == ent_reg) ? val_reg : '0;
                sweep_next = sweep_reg + ENT_W'(1);
                if (sweep_reg == ENT_W'(PAGE_ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    rv_next    = '0;
                    found_next = 1'b0;
                    full_next  = 1'b0;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            used_reg  <= '0;
            page_reg  <= '0;
            sweep_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            used_reg  <= used_next;
            page_reg  <= page_next;
            sweep_reg <= sweep_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        slot_reg    <= slot_next;
        slot_ok_reg <= slot_ok_next;
        ent_reg     <= ent_next;
        val_reg     <= val_next;
        rv_reg      <= rv_next;
        found_reg   <= found_next;
        full_reg    <= full_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign read_value = rv_reg;
    assign page_found = found_reg;
    assign pool_full  = full_reg;

endmodule

[hdl/tlsa_ram.sv]
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module tlsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/tlsa_checker.sv]
// ============================================================================
// Two-level sparse array port checker
// Watches the top-level ports for request and result sequencing slips.
// ============================================================================
`include "two_level_sparse_array_top_defines.svh"

module tlsa_checker
    import tlsa_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input logic [OUT_W-1:0] read_value,
    input logic             page_found,
    input logic             pool_full
);

    logic req_beat;

    assign req_beat = start && !busy;

    // A taken request keeps the block busy and silent for the next cycle.
    `TLSA_CHK_NEXT(a_busy_after_beat, req_beat, busy && !done)
    // Results are only shown once the block is free again.
    `TLSA_CHK_SAME(a_done_when_free, done, !busy)
    // A dropped write never claims a page and never returns data.
    `TLSA_CHK_SAME(a_full_exclusive, done && pool_full, !page_found && (read_value == '0))

endmodule

bind two_level_sparse_array_top tlsa_checker u_tlsa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .read_value  (read_value),
    .page_found  (page_found),
    .pool_full   (pool_full)
);

[tb/testbench.sv]
`timescale 1ns / 100ps
// ============================================================================
// Two-level sparse array testbench
// Drives read, write, clear and unused requests through the start/busy
// handshake, predicts every response from a local copy of the directory,
// the page pool and the written bits, and checks each done beat in order.
// ============================================================================
module testbench;
    import tlsa_pkg::*;

    localparam int WORDS          = POOL_PAGES * PAGE_ENTRIES;
    localparam int RANDOM_ITEMS   = 1350;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 300;
    localparam logic [31:0] VALUE_MASK = (VAL_W >= 32) ? 32'hFFFF_FFFF : ((32'd1 << VAL_W) - 1);

    typedef struct {
        req_t             kind;
        logic [IDX_W-1:0] idx;
        logic [31:0]      val;
        bit               drain;
    } request_t;

    typedef struct {
        logic [OUT_W-1:0] value;
        logic             found;
        logic             full;
    } answer_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic [1:0]       req_type = REQ_READ;
    logic [IDX_W-1:0] entry_index = '0;
    logic [31:0]      write_value = '0;
    logic             busy;
    logic             done;
    logic [OUT_W-1:0] read_value;
    logic             page_found;
    logic             pool_full;

    // Local image of the array.
    logic             dir_valid [SLOTS];
    logic [PG_W-1:0]  dir_page [SLOTS];
    logic [31:0]      word_mem [WORDS];
    bit               word_written [WORDS];
    int               pages_taken;

    request_t pending_reqs[$];
    answer_t  expected_answers[$];

    int in_flight;
    int gap_left;
    int burst_left;
    int idle_cycles;
    int fail_count;
    int reported;
    int n_read, n_write, n_clear, n_none;
    int n_found, n_full;

    two_level_sparse_array_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .entry_index (entry_index),
        .write_value (write_value),
        .done        (done),
        .read_value  (read_value),
        .page_found  (page_found),
        .pool_full   (pool_full)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function void clear_model();
        for (int s = 0; s < SLOTS; s++)
        begin
            dir_valid[s] = 1'b0;
            dir_page[s]  = '0;
        end
        for (int w = 0; w < WORDS; w++)
        begin
            word_written[w] = 1'b0;
        end
        pages_taken = 0;
    endfunction

    // Updates the local image with one request and returns its response.
    function answer_t apply_request(input request_t rq);
        answer_t a;
        int      slot;
        int      ent;
        int      w;
        a.value = '0;
        a.found = 1'b0;
        a.full  = 1'b0;
        slot = rq.idx[IDX_W-1:ENT_W];
        ent  = rq.idx[ENT_W-1:0];
        case (rq.kind)
            REQ_READ:
            begin
                if (slot < SLOTS && dir_valid[slot])
                begin
                    a.found = 1'b1;
                    w = dir_page[slot] * PAGE_ENTRIES + ent;
                    if (word_written[w])
                        a.value = word_mem[w];
                end
            end
            REQ_WRITE:
            begin
                if (slot < SLOTS)
                begin
                    if (dir_valid[slot])
                        a.found = 1'b1;
                    else if (pages_taken < POOL_PAGES)
                    begin
                        dir_page[slot]  = PG_W'(pages_taken);
                        dir_valid[slot] = 1'b1;
                        pages_taken++;
                    end
                    else
                        a.full = 1'b1;
                    if (!a.full)
                    begin
                        w = dir_page[slot] * PAGE_ENTRIES + ent;
                        word_mem[w]     = rq.val & VALUE_MASK;
                        word_written[w] = 1'b1;
                    end
                end
            end
            REQ_CLEAR:
                clear_model();
            default:
                ;
        endcase
        return a;
    endfunction

    task add_req(input req_t kind, input logic [IDX_W-1:0] idx, input logic [31:0] val,
                 input bit drain);
        request_t rq;
        rq.kind  = kind;
        rq.idx   = idx;
        rq.val   = val;
        rq.drain = drain;
        pending_reqs.push_back(rq);
    endtask

    // Most traffic goes to a few hot slots so that pages get reused.
    function logic [SLOT_W-1:0] pick_slot();
        logic [SLOT_W-1:0] hot [8];
        hot = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'h10, 8'h42, 8'hFE};
        if ($urandom_range(0, 3) == 0)
            return SLOT_W'($urandom_range(0, SLOTS - 1));
        return hot[$urandom_range(0, 7)];
    endfunction

    function logic [ENT_W-1:0] pick_entry();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return ENT_W'($urandom_range(0, PAGE_ENTRIES - 1));
    endfunction

    function logic [31:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return 32'h0000_0000;
        if (roll == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return 0;
        if (roll < 80)
            return $urandom_range(1, 4);
        if (roll < 95)
            return $urandom_range(5, 20);
        return $urandom_range(21, 300);
    endfunction

    // Driver: holds a request until it is taken, with random idle gaps between bursts.
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        bit       took;
        int       flight;
        request_t cur;
        if (!rst_n)
        begin
            start       <= 1'b0;
            req_type    <= REQ_READ;
            entry_index <= '0;
            write_value <= '0;
            in_flight   <= 0;
            gap_left    = 0;
            burst_left  = $urandom_range(1, 40);
        end
        else
        begin
            took = start && !busy;
            if (took)
            begin
                cur = pending_reqs.pop_front();
                expected_answers.push_back(apply_request(cur));
                case (cur.kind)
                    REQ_READ:  n_read++;
                    REQ_WRITE: n_write++;
                    REQ_CLEAR: n_clear++;
                    default:   n_none++;
                endcase
                burst_left--;
                if (burst_left <= 0)
                begin
                    gap_left   = pick_gap();
                    burst_left = $urandom_range(1, 40);
                end
            end
            flight = in_flight + (took ? 1 : 0) - (done ? 1 : 0);
            in_flight <= flight;
            if (start && !took)
                ;
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_reqs.size() != 0 && (!pending_reqs[0].drain || flight == 0))
            begin
                start       <= 1'b1;
                req_type    <= pending_reqs[0].kind;
                entry_index <= pending_reqs[0].idx;
                write_value <= pending_reqs[0].val;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: every done beat is matched against the oldest prediction.
    always @(posedge clk)
    begin : check_proc
        answer_t want;
        if (rst_n && done)
        begin
            if (expected_answers.size() == 0)
            begin
                fail_count++;
                if (reported < 10)
                    $display("Unexpected result beat at %0t: read_value %h", $time, read_value);
                reported++;
            end
            else
            begin
                want = expected_answers.pop_front();
                if (read_value !== want.value || page_found !== want.found ||
                    pool_full !== want.full)
                begin
                    fail_count++;
                    if (reported < 10)
                        $display("Mismatch at %0t: value %h/%h found %b/%b full %b/%b",
                                 $time, read_value, want.value, page_found, want.found,
                                 pool_full, want.full);
                    reported++;
                end
                if (want.found)
                    n_found++;
                if (want.full)
                    n_full++;
            end
        end
    end

    // Watchdog on cycles with no beat in either direction.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired with %0d requests pending", pending_reqs.size());
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : run_proc
        int                directed;
        int                episode;
        int                n;
        int                stride;
        logic [SLOT_W-1:0] slot;
        logic [ENT_W-1:0]  ents [3];
        bit                first_fill;

        clear_model();
        first_fill = 1'b1;

        // Directed part: empty reads, unused code, extremes, overwrite, clear.
        add_req(REQ_READ,  16'h0000, 32'h0000_0000, 1'b0);
        add_req(REQ_READ,  16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        add_req(REQ_NONE,  16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        add_req(REQ_WRITE, 16'h0000, 32'hFFFF_FFFF, 1'b0);
        add_req(REQ_READ,  16'h0000, 32'h0000_0000, 1'b0);
        add_req(REQ_READ,  16'h0001, 32'h0000_0000, 1'b0);
        add_req(REQ_WRITE, 16'h00FF, 32'h0000_0000, 1'b0);
        add_req(REQ_READ,  16'h00FF, 32'hFFFF_FFFF, 1'b0);
        add_req(REQ_WRITE, 16'hFFFF, 32'hA5A5_5A5A, 1'b0);
        add_req(REQ_READ,  16'hFFFF, 32'h0000_0000, 1'b0);
        add_req(REQ_READ,  16'hFF00, 32'h0000_0000, 1'b0);
        add_req(REQ_NONE,  16'h0000, 32'h0000_0000, 1'b0);
        add_req(REQ_WRITE, 16'h0000, 32'h0000_0001, 1'b0);
        add_req(REQ_READ,  16'h0000, 32'h0000_0000, 1'b0);
        add_req(REQ_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        add_req(REQ_READ,  16'h0000, 32'h0000_0000, 1'b0);
        add_req(REQ_READ,  16'hFFFF, 32'h0000_0000, 1'b0);
        add_req(REQ_WRITE, 16'h1234, 32'h5555_5555, 1'b1);
        add_req(REQ_READ,  16'h1234, 32'h0000_0000, 1'b0);
        add_req(REQ_CLEAR, 16'h0000, 32'h0000_0000, 1'b1);
        directed = pending_reqs.size();

        while (pending_reqs.size() < directed + RANDOM_ITEMS)
        begin
            episode = first_fill ? 7 : $urandom_range(0, 9);
            case (episode)
                0, 1, 2, 3, 4:
                begin
                    // Write a few entries of one slot and read them back.
                    slot = pick_slot();
                    n = $urandom_range(1, 3);
                    for (int i = 0; i < n; i++)
                    begin
                        ents[i] = pick_entry();
                        add_req(REQ_WRITE, {slot, ents[i]}, pick_value(), 1'b0);
                    end
                    for (int i = n - 1; i >= 0; i--)
                        add_req(REQ_READ, {slot, ents[i]}, $urandom, 1'b0);
                    add_req(REQ_READ, {slot, pick_entry()}, $urandom, 1'b0);
                end
                5, 6:
                begin
                    // Noise: any code, any index, any value.
                    n = $urandom_range(6, 12);
                    for (int i = 0; i < n; i++)
                    begin
                        case ($urandom_range(0, 15))
                            0:       add_req(REQ_CLEAR, IDX_W'($urandom), $urandom, 1'b0);
                            1, 2:    add_req(REQ_NONE, IDX_W'($urandom), $urandom, 1'b0);
                            3, 4, 5, 6, 7, 8:
                                     add_req(REQ_WRITE, IDX_W'($urandom), $urandom, 1'b0);
                            default: add_req(REQ_READ, IDX_W'($urandom), $urandom, 1'b0);
                        endcase
                    end
                end
                7:
                begin
                    // Walk distinct slots until the page pool runs dry.
                    first_fill = 1'b0;
                    slot   = SLOT_W'($urandom_range(0, SLOTS - 1));
                    stride = 2 * $urandom_range(0, 127) + 1;
                    n      = $urandom_range(POOL_PAGES + 2, POOL_PAGES + 8);
                    for (int i = 0; i < n; i++)
                    begin
                        add_req(REQ_WRITE, {slot, pick_entry()}, pick_value(), 1'b0);
                        if ($urandom_range(0, 3) == 0)
                            add_req(REQ_READ, {slot, pick_entry()}, $urandom, 1'b0);
                        slot = slot + SLOT_W'(stride);
                    end
                end
                8:
                    add_req(REQ_CLEAR, IDX_W'($urandom), $urandom,
                            $urandom_range(0, 1) == 1);
                default:
                begin
                    slot = pick_slot();
                    n = $urandom_range(4, 8);
                    for (int i = 0; i < n; i++)
                        add_req(REQ_READ, {slot, pick_entry()}, $urandom, 1'b0);
                end
            endcase
        end

        repeat (7) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (pending_reqs.size() != 0 || in_flight != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_answers.size() != 0)
        begin
            $display("%0d predicted results never arrived", expected_answers.size());
            fail_count += expected_answers.size();
        end
        $display("Requests sent: %0d reads, %0d writes, %0d clears, %0d unused codes",
                 n_read, n_write, n_clear, n_none);
        $display("Responses: %0d with a page present, %0d writes dropped on a full pool, %0d bad",
                 n_found, n_full, fail_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
